// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, for the phase
// unwrapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset.
`define CPHU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check at every edge, reset included.
`define CPHU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hdl/cphu_pkg.sv -----
// ----------------------------------------------------------------------------
// cphu_pkg
// Types, field widths, register indexes and saturation helper for the
// CSI phase unwrapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cphu_pkg;

    localparam int RAW_W      = 16;
    localparam int CARRIER_W  = 8;
    localparam int ADDR_W     = 56;
    localparam int OUT_W      = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int WIDE_W     = 34;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_COUNT = 4;
    localparam int MASK_W     = 64;

    localparam int DEF_MAX_SENDERS  = 16;
    localparam int DEF_NUM_CARRIERS = 256;

    typedef logic signed [RAW_W-1:0]  raw_phase_t;
    typedef logic [CARRIER_W-1:0]     carrier_t;
    typedef logic [ADDR_W-1:0]        sender_addr_t;
    typedef logic signed [OUT_W-1:0]  phase_t;
    typedef logic [SLOT_OUT_W-1:0]    slot_out_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam cfg_idx_t CFG_DIFF_ENABLE   = 3'd0;
    localparam cfg_idx_t CFG_MULTI_ENABLE  = 3'd1;
    localparam cfg_idx_t CFG_GUARD_ENABLE  = 3'd2;
    localparam cfg_idx_t CFG_GUARD_MASK_0  = 3'd3;
    localparam cfg_idx_t CFG_GUARD_MASK_1  = 3'd4;
    localparam cfg_idx_t CFG_GUARD_MASK_2  = 3'd5;
    localparam cfg_idx_t CFG_GUARD_MASK_3  = 3'd6;

    localparam wide_t HALF_TURN     = 34'sd32768;
    localparam wide_t NEG_HALF_TURN = -34'sd32768;
    localparam wide_t SAT_MAX       = 34'sd2147483647;
    localparam wide_t SAT_MIN       = -34'sd2147483648;
    localparam phase_t PHASE_MAX    = 32'sh7FFF_FFFF;
    localparam phase_t PHASE_MIN    = 32'sh8000_0000;
    localparam raw_phase_t RAW_MIN  = 16'sh8000;

    function automatic phase_t sat32(input wide_t v);
        phase_t r;
        if (v > SAT_MAX)
        begin
            r = PHASE_MAX;
        end
        else if (v < SAT_MIN)
        begin
            r = PHASE_MIN;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/cphu_sample_if.sv -----
// ----------------------------------------------------------------------------
// cphu_sample_if
// Sample channel: one subcarrier phase sample per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cphu_sample_if;
    logic                   valid;
    logic                   ready;
    cphu_pkg::raw_phase_t   phase_in;
    cphu_pkg::carrier_t     carrier_index;
    logic                   frame_start;
    cphu_pkg::sender_addr_t sender_addr;
    cphu_pkg::raw_phase_t   ref_phase;

    modport source (
        output valid, phase_in, carrier_index, frame_start, sender_addr, ref_phase,
        input  ready
    );

    modport sink (
        input  valid, phase_in, carrier_index, frame_start, sender_addr, ref_phase,
        output ready
    );
endinterface

// ----- hdl/cphu_result_if.sv -----
// ----------------------------------------------------------------------------
// cphu_result_if
// Result channel: one unwrapped phase per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cphu_result_if;
    logic                valid;
    logic                ready;
    cphu_pkg::phase_t    phase_out;
    cphu_pkg::slot_out_t sender_slot;
    logic                was_guard;

    modport source (
        output valid, phase_out, sender_slot, was_guard,
        input  ready
    );

    modport sink (
        input  valid, phase_out, sender_slot, was_guard,
        output ready
    );
endinterface

// ----- hdl/csi_phase_unwrap_unit.sv -----
// ----------------------------------------------------------------------------
// csi_phase_unwrap_unit
// CSI subcarrier phase unwrapper with per-sender frame differencing.
// ----------------------------------------------------------------------------
// Takes one sample transfer per clock, unless the result side stalls, and
// returns one result per sample via the stage 1 and output registers. The
// rate is set by the unwrap loop (offset, previous phase and chain state
// update per sample) and the history memory, read when a sample is taken,
// written when it leaves stage 1, and forwarded for back-to-back hits on
// the same entry. Sender lookup compares all filled table slots in parallel
// on a frame start. The history memory holds MAX_SENDERS * NUM_CARRIERS
// phases and has no clearing pass: it is ready right after reset.
// Configuration must be written only while idle, unchecked by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csi_phase_unwrap_unit #(
    parameter int MAX_SENDERS  = cphu_pkg::DEF_MAX_SENDERS,
    parameter int NUM_CARRIERS = cphu_pkg::DEF_NUM_CARRIERS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cphu_sample_if.sink                     sample,
    cphu_result_if.source                   result,
    input  logic                            cfg_we,
    input  cphu_pkg::cfg_idx_t              cfg_index,
    input  logic [cphu_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W     = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
    localparam int COUNT_W    = $clog2(MAX_SENDERS + 1);
    localparam int CAR_W      = $clog2(NUM_CARRIERS);
    localparam int HIST_DEPTH = MAX_SENDERS * NUM_CARRIERS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int RED_W      = (CAR_W > cphu_pkg::CARRIER_W) ? CAR_W + 1
                                                              : cphu_pkg::CARRIER_W + 1;
    localparam int RED_STEPS  = ((1 << cphu_pkg::CARRIER_W) - 1) / NUM_CARRIERS;

    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(MAX_SENDERS - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SENDERS);
    localparam logic [RED_W-1:0]   RED_N     = RED_W'(NUM_CARRIERS);

    // configuration
    logic                                  diff_en_reg;
    logic                                  multi_en_reg;
    logic                                  guard_en_reg;
    logic [cphu_pkg::MASK_W-1:0]           guard_mask_reg [cphu_pkg::MASK_COUNT];

    // sender tracking
    cphu_pkg::sender_addr_t                table_reg [MAX_SENDERS];
    logic [COUNT_W-1:0]                    count_reg;
    logic [COUNT_W-1:0]                    count_next;
    logic [MAX_SENDERS-1:0]                flags_reg;
    logic [MAX_SENDERS-1:0]                flags_next;
    logic [SLOT_W-1:0]                     cur_slot_reg;
    logic                                  frame_open_reg;

    // unwrap chain
    cphu_pkg::phase_t                      off_reg;
    cphu_pkg::phase_t                      off_next;
    cphu_pkg::phase_t                      last_reg;
    cphu_pkg::phase_t                      last_next;
    logic                                  chain_reg;
    logic                                  chain_next;

    // history memory
    cphu_pkg::phase_t                      hist_mem [HIST_DEPTH];
    cphu_pkg::phase_t                      mem_q_reg;
    logic                                  byp_reg;
    logic                                  byp_next;
    cphu_pkg::phase_t                      byp_data_reg;

    // stage 1
    logic                                  s1_valid_reg;
    cphu_pkg::raw_phase_t                  s1_phase_reg;
    cphu_pkg::carrier_t                    s1_carrier_reg;
    logic                                  s1_fs_reg;
    cphu_pkg::raw_phase_t                  s1_ref_reg;
    logic [SLOT_W-1:0]                     s1_slot_reg;
    logic                                  s1_first_reg;
    logic [HIST_AW-1:0]                    s1_addr_reg;

    // output register
    logic                                  out_valid_reg;
    cphu_pkg::phase_t                      out_phase_reg;
    cphu_pkg::slot_out_t                   out_slot_reg;
    logic                                  out_guard_reg;

    // stage 0 signals
    logic                                  accept;
    logic [MAX_SENDERS-1:0]                hit;
    logic [SLOT_W-1:0]                     hit_slot;
    logic [SLOT_W-1:0]                     slot_new;
    logic                                  tbl_we;
    logic [SLOT_W-1:0]                     slot_item;
    logic                                  first_item;
    logic [RED_W-1:0]                      car_red;
    logic [HIST_AW-1:0]                    rd_addr;

    // stage 1 signals
    logic                                  s1_adv;
    logic                                  guard_out;
    cphu_pkg::phase_t                      off_cur;
    cphu_pkg::phase_t                      last_cur;
    logic                                  broken_cur;
    cphu_pkg::wide_t                       x;
    cphu_pkg::wide_t                       d;
    logic signed [cphu_pkg::RAW_W-1:0]     d_low;
    logic signed [cphu_pkg::RAW_W:0]       dp;
    cphu_pkg::wide_t                       xw;
    cphu_pkg::phase_t                      u;
    cphu_pkg::phase_t                      hist;
    cphu_pkg::phase_t                      res;
    logic                                  hist_we;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_adv;
    assign accept       = sample.valid && sample.ready;

    assign result.valid       = out_valid_reg;
    assign result.phase_out   = out_phase_reg;
    assign result.sender_slot = out_slot_reg;
    assign result.was_guard   = out_guard_reg;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_en_reg       <= 1'b1;
            multi_en_reg      <= 1'b1;
            guard_en_reg      <= 1'b1;
            guard_mask_reg[0] <= '1;
            guard_mask_reg[1] <= cphu_pkg::MASK_W'(1);
            guard_mask_reg[2] <= '0;
            guard_mask_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cphu_pkg::CFG_DIFF_ENABLE:  diff_en_reg       <= cfg_data[0];
                cphu_pkg::CFG_MULTI_ENABLE: multi_en_reg      <= cfg_data[0];
                cphu_pkg::CFG_GUARD_ENABLE: guard_en_reg      <= cfg_data[0];
                cphu_pkg::CFG_GUARD_MASK_0: guard_mask_reg[0] <= cfg_data;
                cphu_pkg::CFG_GUARD_MASK_1: guard_mask_reg[1] <= cfg_data;
                cphu_pkg::CFG_GUARD_MASK_2: guard_mask_reg[2] <= cfg_data;
                cphu_pkg::CFG_GUARD_MASK_3: guard_mask_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: sender lookup, flags, history address
    // ------------------------------------------------------------------------
    always_comb
    begin
        hit      = '0;
        hit_slot = '0;
        for (int i = 0; i < MAX_SENDERS; i++)
        begin
            hit[i] = (COUNT_W'(i) < count_reg) && (table_reg[i] == sample.sender_addr);
        end
        for (int i = 0; i < MAX_SENDERS; i++)
        begin
            if (hit[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        slot_new   = '0;
        tbl_we     = 1'b0;
        count_next = count_reg;
        if (multi_en_reg)
        begin
            if (|hit)
            begin
                slot_new = hit_slot;
            end
            else
            begin
                tbl_we = 1'b1;
                if (count_reg < MAX_COUNT)
                begin
                    slot_new   = SLOT_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    slot_new = LAST_SLOT;
                end
            end
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (sample.frame_start && frame_open_reg)
        begin
            flags_next[cur_slot_reg] = 1'b0;
        end
        slot_item  = sample.frame_start ? slot_new : cur_slot_reg;
        first_item = flags_next[slot_item];
    end

    always_comb
    begin
        car_red = RED_W'(sample.carrier_index);
        for (int k = 0; k < RED_STEPS; k++)
        begin
            if (car_red >= RED_N)
            begin
                car_red = car_red - RED_N;
            end
        end
        rd_addr = HIST_AW'(slot_item) * HIST_AW'(NUM_CARRIERS)
                + HIST_AW'(car_red[CAR_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            flags_reg      <= '1;
            cur_slot_reg   <= '0;
            frame_open_reg <= 1'b0;
        end
        else if (accept && sample.frame_start)
        begin
            count_reg      <= count_next;
            flags_reg      <= flags_next;
            cur_slot_reg   <= slot_new;
            frame_open_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && sample.frame_start && tbl_we)
        begin
            table_reg[slot_new] <= sample.sender_addr;
        end
    end

    // ------------------------------------------------------------------------
    // History memory
    // ------------------------------------------------------------------------
    assign byp_next = hist_we && (s1_addr_reg == rd_addr);

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[s1_addr_reg] <= u;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_q_reg    <= hist_mem[rd_addr];
            byp_reg      <= byp_next;
            byp_data_reg <= u;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_phase_reg   <= sample.phase_in;
            s1_carrier_reg <= sample.carrier_index;
            s1_fs_reg      <= sample.frame_start;
            s1_ref_reg     <= sample.ref_phase;
            s1_slot_reg    <= slot_item;
            s1_first_reg   <= first_item;
            s1_addr_reg    <= rd_addr;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: guard, unwrap, difference
    // ------------------------------------------------------------------------
    always_comb
    begin
        guard_out  = guard_mask_reg[s1_carrier_reg[7:6]][s1_carrier_reg[5:0]] && guard_en_reg;
        off_cur    = s1_fs_reg ? cphu_pkg::OUT_W'(s1_ref_reg) : off_reg;
        last_cur   = s1_fs_reg ? '0 : last_reg;
        broken_cur = s1_fs_reg || chain_reg;

        x     = cphu_pkg::WIDE_W'(s1_phase_reg) - cphu_pkg::WIDE_W'(off_cur);
        d     = x - cphu_pkg::WIDE_W'(last_cur);
        d_low = d[cphu_pkg::RAW_W-1:0];
        if (d > cphu_pkg::HALF_TURN)
        begin
            dp = (d_low == cphu_pkg::RAW_MIN) ? 17'sd32768 : (cphu_pkg::RAW_W + 1)'(d_low);
        end
        else if (d < cphu_pkg::NEG_HALF_TURN)
        begin
            dp = (cphu_pkg::RAW_W + 1)'(d_low);
        end
        else
        begin
            dp = d[cphu_pkg::RAW_W:0];
        end
        xw = broken_cur ? x : cphu_pkg::WIDE_W'(last_cur) + cphu_pkg::WIDE_W'(dp);
        u  = cphu_pkg::sat32(xw);

        hist = byp_reg ? byp_data_reg : mem_q_reg;
        if (diff_en_reg && !s1_first_reg)
        begin
            res = cphu_pkg::sat32(cphu_pkg::WIDE_W'(u) - cphu_pkg::WIDE_W'(hist));
        end
        else
        begin
            res = u;
        end
        hist_we = s1_adv && diff_en_reg && !guard_out;

        if (guard_out)
        begin
            off_next   = off_cur;
            last_next  = last_cur;
            chain_next = 1'b1;
        end
        else
        begin
            off_next   = cphu_pkg::sat32(cphu_pkg::WIDE_W'(s1_phase_reg)
                                         - cphu_pkg::WIDE_W'(u));
            last_next  = u;
            chain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            last_reg  <= '0;
            chain_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            off_reg   <= off_next;
            last_reg  <= last_next;
            chain_reg <= chain_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_phase_reg <= guard_out ? '0 : res;
            out_slot_reg  <= cphu_pkg::SLOT_OUT_W'(s1_slot_reg);
            out_guard_reg <= guard_out;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `CPHU_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid_reg && !s1_valid_reg, "pipeline not empty in reset")
    `CPHU_ASSERT(a_count_bound, count_reg <= MAX_COUNT, "sender count above table size")
    `CPHU_ASSERT(a_hit_unique, sample.valid |-> $onehot0(hit), "sender address found in two slots")
    `CPHU_ASSERT(a_guard_zero, out_valid_reg && out_guard_reg |-> out_phase_reg == '0, "guard result not zero")
    `CPHU_ASSERT(a_single_slot, accept && sample.frame_start && !multi_en_reg |=> cur_slot_reg == '0, "single-sender frame not on slot zero")

endmodule

// ----- tb/csi_phase_unwrap_unit_tb.sv -----
// ----------------------------------------------------------------------------
// csi_phase_unwrap_unit_tb
// Self-checking bench for the CSI phase unwrapper. A scoreboard class keeps
// its own copy of the sender table, history, offset and chain state and
// predicts every result from each accepted sample transfer. The stimulus
// covers pre-frame samples, a priming pass that fills every history slot on
// the carrier grid in use, directed corner cases, and random frame traffic
// under several register settings, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csi_phase_unwrap_unit_tb;

    localparam int NSLOT      = cphu_pkg::DEF_MAX_SENDERS;
    localparam int NCAR       = cphu_pkg::DEF_NUM_CARRIERS;
    localparam int HALF_UNITS = 32768;
    localparam int TURN_UNITS = 65536;
    localparam int CAR_STEP   = 8;

    typedef struct packed {
        cphu_pkg::phase_t    phase;
        cphu_pkg::slot_out_t slot;
        logic                guard;
    } unwrap_result_t;

    class phase_scoreboard;
        bit                     diff_on;
        bit                     multi_on;
        bit                     guard_on;
        logic [63:0]            guard_bits [cphu_pkg::MASK_COUNT];
        cphu_pkg::phase_t       hist_mem [NSLOT][NCAR];
        cphu_pkg::sender_addr_t addr_tab [NSLOT];
        int                     slots_used;
        bit                     fresh_slot [NSLOT];
        cphu_pkg::phase_t       offset_acc;
        cphu_pkg::phase_t       prev_unwrapped;
        bit                     chain_cut;
        bit                     frame_seen;
        int                     active_slot;
        unwrap_result_t         pending_q [$];
        int                     errors;

        function new();
            int i;
            diff_on = 1'b1;
            multi_on = 1'b1;
            guard_on = 1'b1;
            guard_bits[0] = '1;
            guard_bits[1] = 64'd1;
            guard_bits[2] = '0;
            guard_bits[3] = '0;
            for (i = 0; i < NSLOT; i++)
            begin
                fresh_slot[i] = 1'b1;
            end
            slots_used = 0;
            offset_acc = '0;
            prev_unwrapped = '0;
            chain_cut = 1'b1;
            frame_seen = 1'b0;
            active_slot = 0;
            errors = 0;
        endfunction

        function void write_reg(input cphu_pkg::cfg_idx_t idx, input logic [63:0] v);
            case (idx)
                cphu_pkg::CFG_DIFF_ENABLE:  diff_on = v[0];
                cphu_pkg::CFG_MULTI_ENABLE: multi_on = v[0];
                cphu_pkg::CFG_GUARD_ENABLE: guard_on = v[0];
                cphu_pkg::CFG_GUARD_MASK_0: guard_bits[0] = v;
                cphu_pkg::CFG_GUARD_MASK_1: guard_bits[1] = v;
                cphu_pkg::CFG_GUARD_MASK_2: guard_bits[2] = v;
                cphu_pkg::CFG_GUARD_MASK_3: guard_bits[3] = v;
                default: ;
            endcase
        endfunction

        function cphu_pkg::phase_t clamp32(input longint v);
            cphu_pkg::phase_t r;
            if (v > longint'(32'sh7FFF_FFFF))
            begin
                r = 32'sh7FFF_FFFF;
            end
            else if (v < -longint'(32'sh7FFF_FFFF) - 1)
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        endfunction

        function int lookup_slot(input cphu_pkg::sender_addr_t a);
            int i;
            for (i = 0; i < slots_used; i++)
            begin
                if (addr_tab[i] == a)
                begin
                    return i;
                end
            end
            if (slots_used < NSLOT)
            begin
                slots_used++;
            end
            addr_tab[slots_used - 1] = a;
            return slots_used - 1;
        endfunction

        function void note_sample(input cphu_pkg::raw_phase_t ph, input cphu_pkg::carrier_t c,
                                  input logic fs, input cphu_pkg::sender_addr_t a,
                                  input cphu_pkg::raw_phase_t r);
            unwrap_result_t   e;
            longint           x;
            longint           d;
            longint           n;
            cphu_pkg::phase_t u;
            if (fs)
            begin
                if (frame_seen)
                begin
                    fresh_slot[active_slot] = 1'b0;
                end
                active_slot = multi_on ? lookup_slot(a) : 0;
                offset_acc = cphu_pkg::phase_t'(r);
                prev_unwrapped = '0;
                chain_cut = 1'b1;
                frame_seen = 1'b1;
            end
            e.slot = active_slot[cphu_pkg::SLOT_OUT_W-1:0];
            if (guard_on && guard_bits[c[7:6]][c[5:0]])
            begin
                chain_cut = 1'b1;
                e.phase = '0;
                e.guard = 1'b1;
            end
            else
            begin
                x = longint'(ph) - longint'(offset_acc);
                if (!chain_cut)
                begin
                    d = x - longint'(prev_unwrapped);
                    if (d > HALF_UNITS)
                    begin
                        n = (d - HALF_UNITS + (TURN_UNITS - 1)) / TURN_UNITS;
                        x = x - n * TURN_UNITS;
                    end
                    else if (d < -HALF_UNITS)
                    begin
                        n = (-HALF_UNITS - d + (TURN_UNITS - 1)) / TURN_UNITS;
                        x = x + n * TURN_UNITS;
                    end
                end
                u = clamp32(x);
                offset_acc = clamp32(longint'(ph) - longint'(u));
                prev_unwrapped = u;
                chain_cut = 1'b0;
                e.phase = u;
                if (diff_on)
                begin
                    if (!fresh_slot[active_slot])
                    begin
                        e.phase = clamp32(longint'(u) - longint'(hist_mem[active_slot][c]));
                    end
                    hist_mem[active_slot][c] = u;
                end
                e.guard = 1'b0;
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(input cphu_pkg::phase_t p, input cphu_pkg::slot_out_t s,
                                   input logic g);
            unwrap_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("result transfer with nothing expected: phase_out %0d", p);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (p !== e.phase)
                begin
                    $error("phase_out expected %0d actual %0d", e.phase, p);
                    errors++;
                end
                if (s !== e.slot)
                begin
                    $error("sender_slot expected %0d actual %0d", e.slot, s);
                    errors++;
                end
                if (g !== e.guard)
                begin
                    $error("was_guard expected %0d actual %0d", e.guard, g);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    cphu_pkg::cfg_idx_t              cfg_index;
    logic [cphu_pkg::CFG_DATA_W-1:0] cfg_data;

    cphu_sample_if sample_ch ();
    cphu_result_if result_ch ();

    phase_scoreboard sb = new();

    cphu_pkg::sender_addr_t addr_pool [NSLOT];
    int                     samples_sent;
    int                     burst_left;
    int                     stall_left;
    bit                     tx_gaps_on;
    bit                     rx_stall_on;

    csi_phase_unwrap_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("csi_phase_unwrap_unit_tb: errors");
        $finish;
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rx_stall_on)
        begin
            result_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            sb.check_result(result_ch.phase_out, result_ch.sender_slot, result_ch.was_guard);
        end
    end

    function automatic cphu_pkg::sender_addr_t rand_addr();
        return cphu_pkg::sender_addr_t'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] rand_mask();
        return {$urandom, $urandom};
    endfunction

    function automatic cphu_pkg::carrier_t rand_carrier();
        return cphu_pkg::carrier_t'(CAR_STEP * $urandom_range(0, NCAR / CAR_STEP - 1));
    endfunction

    function automatic cphu_pkg::sender_addr_t pick_addr();
        cphu_pkg::sender_addr_t a;
        if ($urandom_range(0, 4) == 0)
        begin
            a = rand_addr();
        end
        else
        begin
            a = addr_pool[$urandom_range(0, NSLOT - 1)];
        end
        return a;
    endfunction

    function automatic int phase_jump();
        int r;
        case ($urandom_range(0, 4))
            0: r = int'($urandom_range(0, 4000)) - 2000;
            1: r = int'($urandom_range(0, 65535)) - HALF_UNITS;
            2: r = $urandom_range(0, 1) ? HALF_UNITS : -HALF_UNITS;
            3:
            begin
                r = int'($urandom_range(32760, 32776));
                if ($urandom_range(0, 1) == 1)
                begin
                    r = -r;
                end
            end
            default: r = int'($urandom_range(0, 200)) - 100;
        endcase
        return r;
    endfunction

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic push_sample(input cphu_pkg::raw_phase_t ph, input cphu_pkg::carrier_t c,
                               input logic fs, input cphu_pkg::sender_addr_t a,
                               input cphu_pkg::raw_phase_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
            repeat (gap)
            begin
                sample_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        burst_left--;
        sample_ch.valid         <= 1'b1;
        sample_ch.phase_in      <= ph;
        sample_ch.carrier_index <= c;
        sample_ch.frame_start   <= fs;
        sample_ch.sender_addr   <= a;
        sample_ch.ref_phase     <= r;
        do
        begin
            @(posedge clk);
        end
        while (sample_ch.ready !== 1'b1);
        sb.note_sample(ph, c, fs, a, r);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic put_reg(input cphu_pkg::cfg_idx_t idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.write_reg(idx, v);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic d, input logic m, input logic g,
                                input logic [63:0] m0, input logic [63:0] m1,
                                input logic [63:0] m2, input logic [63:0] m3);
        put_reg(cphu_pkg::CFG_DIFF_ENABLE, {63'd0, d});
        put_reg(cphu_pkg::CFG_MULTI_ENABLE, {63'd0, m});
        put_reg(cphu_pkg::CFG_GUARD_ENABLE, {63'd0, g});
        put_reg(cphu_pkg::CFG_GUARD_MASK_0, m0);
        put_reg(cphu_pkg::CFG_GUARD_MASK_1, m1);
        put_reg(cphu_pkg::CFG_GUARD_MASK_2, m2);
        put_reg(cphu_pkg::CFG_GUARD_MASK_3, m3);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items);
        int                   stop_at;
        int                   pause_at;
        int                   len;
        int                   step;
        bit                   held;
        cphu_pkg::carrier_t   c;
        cphu_pkg::raw_phase_t ph;
        stop_at = samples_sent + n_items;
        pause_at = samples_sent + $urandom_range(n_items / 4, (3 * n_items) / 4);
        held = 1'b0;
        while (samples_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                c = cphu_pkg::carrier_t'(CAR_STEP * $urandom_range(0, 6));
                step = CAR_STEP * int'($urandom_range(1, 4));
                len = $urandom_range(2, 40);
                ph = cphu_pkg::raw_phase_t'($urandom);
                push_sample(ph, c, 1'b1, pick_addr(), cphu_pkg::raw_phase_t'($urandom));
                while (len > 1 && int'(c) + step <= 255)
                begin
                    c = cphu_pkg::carrier_t'(int'(c) + step);
                    ph = cphu_pkg::raw_phase_t'(int'(ph) + phase_jump());
                    push_sample(ph, c, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
                    len--;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    push_sample(cphu_pkg::raw_phase_t'($urandom), rand_carrier(),
                                ($urandom_range(0, 3) == 0), pick_addr(),
                                cphu_pkg::raw_phase_t'($urandom));
                end
            end
            if (!held && samples_sent >= pause_at)
            begin
                wait_idle();
                held = 1'b1;
            end
        end
    endtask

    initial
    begin
        int i;
        int k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cphu_pkg::CFG_DIFF_ENABLE;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.phase_in = '0;
        sample_ch.carrier_index = '0;
        sample_ch.frame_start = 1'b0;
        sample_ch.sender_addr = '0;
        sample_ch.ref_phase = '0;
        result_ch.ready = 1'b0;
        samples_sent = 0;
        burst_left = 0;
        stall_left = 0;
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (i = 2; i < NSLOT; i++)
        begin
            addr_pool[i] = cphu_pkg::sender_addr_t'({rand_addr() >> 4, i[3:0]});
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // samples before any frame: slot zero, zero offset
        push_sample(16'sh7FFF, 8'd70, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(cphu_pkg::RAW_MIN, 8'd71, 1'b0, rand_addr(),
                    cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd0, 8'd72, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd5, 8'd10, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd100, 8'd73, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(cphu_pkg::RAW_MIN, 8'd255, 1'b0, rand_addr(),
                    cphu_pkg::raw_phase_t'($urandom));
        wait_idle();

        // fill every history slot on the carrier grid with one frame per sender slot
        apply_config(1'b1, 1'b1, 1'b0, rand_mask(), rand_mask(), rand_mask(), rand_mask());
        for (i = 0; i < NSLOT; i++)
        begin
            for (k = 0; k < NCAR; k += CAR_STEP)
            begin
                push_sample(cphu_pkg::raw_phase_t'($urandom), cphu_pkg::carrier_t'(k),
                            (k == 0), addr_pool[i], cphu_pkg::raw_phase_t'($urandom));
            end
        end
        wait_idle();

        apply_config(1'b1, 1'b1, 1'b1, '1, 64'd1, '0, '0);
        push_sample(16'sd1234, 8'd64, 1'b1, addr_pool[2], cphu_pkg::RAW_MIN);
        push_sample(16'sh7FFF, 8'd72, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(cphu_pkg::RAW_MIN, 8'd80, 1'b0, rand_addr(),
                    cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sh7FFF, 8'd88, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd0, 8'd248, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(cphu_pkg::RAW_MIN, 8'd104, 1'b1, 56'h5A_A55A_0FF0_C33C, 16'sh7FFF);
        push_sample(-16'sd16384, 8'd112, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd16384, 8'd120, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(-16'sd16384, 8'd128, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd16385, 8'd136, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(cphu_pkg::RAW_MIN, 8'd0, 1'b1, addr_pool[15], 16'sd77);
        push_sample(16'sd300, 8'd80, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sh7FFF, 8'd136, 1'b1, addr_pool[0], cphu_pkg::RAW_MIN);
        push_sample(16'sd0, 8'd136, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(-16'sd1, 8'd128, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        push_sample(16'sd42, 8'd144, 1'b1, addr_pool[0], 16'sd0);
        push_sample(-16'sd42, 8'd144, 1'b1, addr_pool[0], 16'sd0);
        push_sample(16'sd9000, 8'd200, 1'b1, addr_pool[1], -16'sd1);
        push_sample(-16'sd9000, 8'd208, 1'b0, rand_addr(), cphu_pkg::raw_phase_t'($urandom));
        wait_idle();

        for (i = 0; i < 8; i++)
        begin
            tx_gaps_on = (i % 3) != 2;
            rx_stall_on = (i % 4) != 3;
            case (i)
                0: apply_config(1'b1, 1'b1, 1'b1, rand_mask(), rand_mask(), rand_mask(),
                                rand_mask());
                1: apply_config(1'b0, 1'b1, 1'b1, '0, '0, '0, '0);
                2: apply_config(1'b1, 1'b0, 1'b1, '1, '1, '1, '1);
                3: apply_config(1'b1, 1'b1, 1'b0, rand_mask(), rand_mask(), rand_mask(),
                                rand_mask());
                4: apply_config(1'b0, 1'b0, 1'b0, rand_mask(), rand_mask(), rand_mask(),
                                rand_mask());
                5: apply_config(1'b1, 1'b1, 1'b1, rand_mask() & rand_mask(),
                                rand_mask() & rand_mask(), rand_mask() & rand_mask(),
                                rand_mask() & rand_mask());
                6: apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), rand_mask(), rand_mask(),
                                rand_mask(), rand_mask());
                default: apply_config(1'b1, 1'b1, 1'b1, '1, 64'd1, '0, '0);
            endcase
            run_random_phase(165);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
        begin
            $display("csi_phase_unwrap_unit_tb: clean");
        end
        else
        begin
            $display("csi_phase_unwrap_unit_tb: errors");
        end
        $finish;
    end

endmodule
